@@ sv/assert_macros.svh @@
// Assertion macros shared by the tilt level RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define TLP_ASSERT_IMPLY(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define TLP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TLP_ASSERT_IMPLY(lbl, ck, rst_n, ante, cons, msg)
`define TLP_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/tlp_pkg.sv @@
// Shared constants, types and the arctangent table of the tilt level block.
// No dependencies; imported by the interfaces and all modules.
package tlp_pkg;

	localparam int ACCEL_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COORD_BITS_DEF   = 10;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int SCALE_W    = 8;
	localparam int TOL_W      = 8;

	localparam int GAIN_RESET   = 6554;
	localparam int SCALE_RESET  = 40;
	localparam int TOL_RESET    = 6;
	localparam int WIDTH_RESET  = 240;
	localparam int HEIGHT_RESET = 135;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 3'd0,
		REG_SCALE  = 3'd1,
		REG_TOL    = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	localparam int EDGE_MARGIN = 8;
	localparam int SMOOTH_FRAC = 8;
	localparam int DOFF_W      = 12;
	localparam int DOT_BITS    = 10;
	localparam int PITCH_BITS  = 15;
	localparam int ROLL_BITS   = 16;

	localparam int SCALED_W  = 31;
	localparam int SQ_W      = 62;
	localparam int ROOT_W    = 31;
	localparam int CORD_IN_W = 33;
	localparam int CORD_W    = 34;
	localparam int ANG_W     = 25;
	localparam int ANG_FRAC  = 8;
	localparam int ATAN_LEN  = 24;
	localparam int ATAN_IDX_W = 5;
	localparam int ATAN_W    = 21;

	localparam int PITCH_LIMIT = 9000;
	localparam int ROLL_LIMIT  = 18000;
	localparam logic signed [ANG_W-1:0] HALF_TURN  = ANG_W'(ROLL_LIMIT << ANG_FRAC);
	localparam logic signed [ANG_W-1:0] ROUND_HALF = ANG_W'(1 << (ANG_FRAC - 1));

	typedef struct packed {
		logic                        start;
		logic                        sel_pitch;
		logic signed [CORD_IN_W-1:0] x;
		logic signed [CORD_IN_W-1:0] y;
	} cordic_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} cordic_stat_t;

	function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0:    v = 21'd1152000;
			5'd1:    v = 21'd680065;
			5'd2:    v = 21'd359328;
			5'd3:    v = 21'd182400;
			5'd4:    v = 21'd91554;
			5'd5:    v = 21'd45822;
			5'd6:    v = 21'd22916;
			5'd7:    v = 21'd11459;
			5'd8:    v = 21'd5730;
			5'd9:    v = 21'd2865;
			5'd10:   v = 21'd1432;
			5'd11:   v = 21'd716;
			5'd12:   v = 21'd358;
			5'd13:   v = 21'd179;
			5'd14:   v = 21'd90;
			5'd15:   v = 21'd45;
			5'd16:   v = 21'd22;
			5'd17:   v = 21'd11;
			5'd18:   v = 21'd6;
			5'd19:   v = 21'd3;
			5'd20:   v = 21'd1;
			5'd21:   v = 21'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ sv/tlp_if.sv @@
// Valid/ready channel interfaces for accelerometer samples and level results.
// Depends on tlp_pkg for default widths.
interface tlp_sample_if import tlp_pkg::*; #(
	parameter int ACCEL_BITS = ACCEL_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [ACCEL_BITS-1:0] accel_x;
	logic signed [ACCEL_BITS-1:0] accel_y;
	logic signed [ACCEL_BITS-1:0] accel_z;
	logic                         restart;
	logic                         sensor_present;

	modport source (output valid, accel_x, accel_y, accel_z, restart, sensor_present,
		input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, restart, sensor_present,
		output ready);
endinterface

interface tlp_result_if import tlp_pkg::*;;
	logic                         valid;
	logic                         ready;
	logic        [DOT_BITS-1:0]   dot_x;
	logic        [DOT_BITS-1:0]   dot_y;
	logic                         is_level;
	logic signed [PITCH_BITS-1:0] pitch_centideg;
	logic signed [ROLL_BITS-1:0]  roll_centideg;
	logic                         sensor_missing;

	modport source (output valid, dot_x, dot_y, is_level, pitch_centideg, roll_centideg,
		sensor_missing, input ready);
	modport sink (input valid, dot_x, dot_y, is_level, pitch_centideg, roll_centideg,
		sensor_missing, output ready);
endinterface

@@ sv/tilt_level_pitch_roll.sv @@
// Tilt level: smoothed dot position, level flag, pitch and roll per sample.
// Depends on tlp_pkg, tlp_if, tlp_isqrt, tlp_cordic and assert_macros.svh.
//
// Usage: samples arrive on the sample channel (valid/ready), one result
// leaves on the result channel for every accepted sample. Registers are
// written through cfg_wr_en/cfg_index/cfg_data; the user must do so only
// while the block is idle, since the block itself does not enforce it.
// A present sample runs through ten steps of the shared multiplier
// (squares, smoothing, dot scaling, offsets, tolerance); the 31-step square
// root starts on its fourth step, then the pitch pass of the shared CORDIC
// follows (roll runs during the multiplier steps). A missing-sensor sample
// skips the multiplier and goes straight to the done state.
// One sample is in work at a time; sample.ready is high only between items,
// so a new sample is not taken before the one in work is through.
// A finished result sits in an output register: the next sample is taken
// while it waits, and a stalled receiver only holds the block once the
// following result is ready. Reset clears the smoothing, loads the
// register defaults and empties the output register.
`include "assert_macros.svh"

module tilt_level_pitch_roll import tlp_pkg::*; #(
	parameter int ACCEL_BITS   = ACCEL_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlp_sample_if.sink            sample,
	tlp_result_if.source          result
);

	localparam int SMOOTH_W = ACCEL_BITS + SMOOTH_FRAC;
	localparam int MA_W     = SMOOTH_W + 1;
	localparam int MB_W     = (ACCEL_BITS > GAIN_W) ? ACCEL_BITS : GAIN_W + 1;
	localparam int MP_W     = MA_W + MB_W;
	localparam int SCALE_SH = SCALED_W - ACCEL_BITS;
	localparam int DOT_SH   = ACCEL_BITS + 4;
	localparam int SQS_W    = 2 * ACCEL_BITS;
	localparam int OFF_W    = COORD_BITS + 1;
	localparam int POS_W    = ((DOFF_W > OFF_W) ? DOFF_W : OFF_W) + 1;
	localparam int DSQ_W    = 2 * OFF_W;
	localparam int MSTEP_W  = 4;

	localparam logic signed [MP_W-1:0]  DOT_BIAS = MP_W'((1 << DOT_SH) - 1);
	localparam logic signed [POS_W-1:0] MARGIN_S = POS_W'(EDGE_MARGIN);

	localparam logic [MSTEP_W-1:0] MS_SQ_Y  = 4'd0;
	localparam logic [MSTEP_W-1:0] MS_SQ_Z  = 4'd1;
	localparam logic [MSTEP_W-1:0] MS_ERR_X = 4'd2;
	localparam logic [MSTEP_W-1:0] MS_ERR_Y = 4'd3;
	localparam logic [MSTEP_W-1:0] MS_DOT_X = 4'd4;
	localparam logic [MSTEP_W-1:0] MS_DOT_Y = 4'd5;
	localparam logic [MSTEP_W-1:0] MS_OFF_X = 4'd6;
	localparam logic [MSTEP_W-1:0] MS_OFF_Y = 4'd7;
	localparam logic [MSTEP_W-1:0] MS_TOL   = 4'd8;
	localparam logic [MSTEP_W-1:0] MS_LAST  = 4'd9;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_MUL   = 5'b00010,
		ST_WAIT  = 5'b00100,
		ST_PITCH = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [MSTEP_W-1:0] mstep_q;

	logic [GAIN_W-1:0]     gain_q;
	logic [SCALE_W-1:0]    scale_q;
	logic [TOL_W-1:0]      tol_q;
	logic [COORD_BITS-1:0] width_q, height_q;

	logic signed [ACCEL_BITS-1:0] ax_q, ay_q, az_q;
	logic                         load_now_q, loaded_q, missing_q;
	logic signed [SMOOTH_W-1:0]   smooth_x_q, smooth_y_q, raw_x8, raw_y8;
	logic signed [MA_W-1:0]       mul_a;
	logic signed [MB_W-1:0]       mul_b;
	logic signed [MP_W-1:0]       prod_q, prod_adj;
	logic [SQS_W-1:0]             sumsq_q;
	logic [DOT_BITS-1:0]          posx_q, posy_q, place_pos;
	logic signed [OFF_W-1:0]      offx_q, offy_q, place_off;
	logic [DSQ_W-1:0]             dsq_q;
	logic                         level_q;
	logic [COORD_BITS-1:0]        place_size;
	logic signed [POS_W-1:0]      center, hi, doff, pos;

	logic                         sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]            sqrt_root, root_q;
	logic                         root_ok_q, roll_ok_q;
	logic signed [SCALED_W-1:0]   scaled_x, scaled_y, scaled_z;
	cordic_req_t                  cordic_req;
	cordic_stat_t                 cordic_stat;
	logic signed [ROLL_BITS-1:0]  cordic_angle;
	logic signed [ROLL_BITS-1:0]  roll_q;
	logic signed [PITCH_BITS-1:0] pitch_q;

	logic                         res_valid_q, res_load;
	logic [DOT_BITS-1:0]          res_dot_x_q, res_dot_y_q;
	logic                         res_level_q, res_missing_q;
	logic signed [PITCH_BITS-1:0] res_pitch_q;
	logic signed [ROLL_BITS-1:0]  res_roll_q;

	assign sample.ready = (state_q == ST_IDLE);
	assign res_load     = (state_q == ST_DONE) && (!res_valid_q || result.ready);

	assign result.valid          = res_valid_q;
	assign result.dot_x          = res_dot_x_q;
	assign result.dot_y          = res_dot_y_q;
	assign result.is_level       = res_level_q;
	assign result.pitch_centideg = res_pitch_q;
	assign result.roll_centideg  = res_roll_q;
	assign result.sensor_missing = res_missing_q;

	assign raw_x8   = $signed({ax_q, {SMOOTH_FRAC{1'b0}}});
	assign raw_y8   = $signed({ay_q, {SMOOTH_FRAC{1'b0}}});
	assign scaled_x = $signed({ax_q, {SCALE_SH{1'b0}}});
	assign scaled_y = $signed({ay_q, {SCALE_SH{1'b0}}});
	assign scaled_z = $signed({az_q, {SCALE_SH{1'b0}}});

	always_comb begin
		case (mstep_q)
			MS_SQ_Y: begin
				mul_a = MA_W'(ay_q);
				mul_b = MB_W'(ay_q);
			end
			MS_SQ_Z: begin
				mul_a = MA_W'(az_q);
				mul_b = MB_W'(az_q);
			end
			MS_ERR_X: begin
				mul_a = MA_W'(raw_x8) - MA_W'(smooth_x_q);
				mul_b = MB_W'($signed({1'b0, gain_q}));
			end
			MS_ERR_Y: begin
				mul_a = MA_W'(raw_y8) - MA_W'(smooth_y_q);
				mul_b = MB_W'($signed({1'b0, gain_q}));
			end
			MS_DOT_X: begin
				mul_a = MA_W'(smooth_x_q);
				mul_b = MB_W'($signed({1'b0, scale_q}));
			end
			MS_DOT_Y: begin
				mul_a = MA_W'(smooth_y_q);
				mul_b = MB_W'($signed({1'b0, scale_q}));
			end
			MS_OFF_X: begin
				mul_a = MA_W'(offx_q);
				mul_b = MB_W'(offx_q);
			end
			MS_OFF_Y: begin
				mul_a = MA_W'(offy_q);
				mul_b = MB_W'(offy_q);
			end
			MS_TOL: begin
				mul_a = MA_W'($signed({1'b0, tol_q}));
				mul_b = MB_W'($signed({1'b0, tol_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		place_size = (mstep_q == MS_DOT_Y) ? width_q : height_q;
		prod_adj   = prod_q + (prod_q[MP_W-1] ? DOT_BIAS : '0);
		doff       = POS_W'(prod_adj >>> DOT_SH);
		center     = POS_W'(place_size >> 1);
		hi         = POS_W'(place_size) - MARGIN_S;
		if (hi < MARGIN_S) begin
			hi = MARGIN_S;
		end
		pos = center + doff;
		if (pos < MARGIN_S) begin
			pos = MARGIN_S;
		end else if (pos > hi) begin
			pos = hi;
		end
		place_off = OFF_W'(pos - center);
		place_pos = DOT_BITS'(pos);
	end

	assign sqrt_start = (state_q == ST_MUL) && (mstep_q == MS_ERR_Y);

	always_comb begin
		cordic_req.sel_pitch = (state_q == ST_WAIT);
		cordic_req.start     = ((state_q == ST_MUL) && (mstep_q == MS_SQ_Y)) ||
			((state_q == ST_WAIT) && root_ok_q && roll_ok_q);
		if (cordic_req.sel_pitch) begin
			cordic_req.x = CORD_IN_W'(root_q);
			cordic_req.y = -CORD_IN_W'(scaled_x);
		end else begin
			cordic_req.x = CORD_IN_W'(scaled_z);
			cordic_req.y = CORD_IN_W'(scaled_y);
		end
	end

	tlp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (SQ_W'(sumsq_q) << (SQ_W - SQS_W)),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	tlp_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cordic_req),
		.stat   (cordic_stat),
		.angle  (cordic_angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mstep_q     <= '0;
			loaded_q    <= 1'b0;
			root_ok_q   <= 1'b0;
			roll_ok_q   <= 1'b0;
			res_valid_q <= 1'b0;
			gain_q      <= GAIN_W'(GAIN_RESET);
			scale_q     <= SCALE_W'(SCALE_RESET);
			tol_q       <= TOL_W'(TOL_RESET);
			width_q     <= COORD_BITS'(WIDTH_RESET);
			height_q    <= COORD_BITS'(HEIGHT_RESET);
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
					REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
					REG_TOL:    tol_q    <= cfg_data[TOL_W-1:0];
					REG_WIDTH:  width_q  <= cfg_data[COORD_BITS-1:0];
					REG_HEIGHT: height_q <= cfg_data[COORD_BITS-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (sqrt_done) begin
				root_ok_q <= 1'b1;
			end
			if (cordic_stat.done && (state_q != ST_PITCH)) begin
				roll_ok_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample.valid) begin
						root_ok_q <= 1'b0;
						roll_ok_q <= 1'b0;
						mstep_q   <= '0;
						if (sample.sensor_present) begin
							loaded_q <= 1'b1;
							state_q  <= ST_MUL;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 1'b1;
					if (mstep_q == MS_LAST) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (root_ok_q && roll_ok_q) begin
						state_q <= ST_PITCH;
					end
				end
				ST_PITCH: begin
					if (cordic_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			ax_q       <= sample.accel_x;
			ay_q       <= sample.accel_y;
			az_q       <= sample.accel_z;
			load_now_q <= sample.restart || !loaded_q;
			missing_q  <= !sample.sensor_present;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			case (mstep_q)
				MS_SQ_Z:  sumsq_q <= SQS_W'(prod_q);
				MS_ERR_X: sumsq_q <= sumsq_q + SQS_W'(prod_q);
				MS_ERR_Y: smooth_x_q <= load_now_q ? raw_x8 :
					smooth_x_q + SMOOTH_W'(prod_q >>> GAIN_W);
				MS_DOT_X: smooth_y_q <= load_now_q ? raw_y8 :
					smooth_y_q + SMOOTH_W'(prod_q >>> GAIN_W);
				MS_DOT_Y: begin
					posx_q <= place_pos;
					offx_q <= place_off;
				end
				MS_OFF_X: begin
					posy_q <= place_pos;
					offy_q <= place_off;
				end
				MS_OFF_Y: dsq_q   <= DSQ_W'(prod_q);
				MS_TOL:   dsq_q   <= dsq_q + DSQ_W'(prod_q);
				MS_LAST:  level_q <= (MP_W'(dsq_q) <= $unsigned(prod_q));
				default: ;
			endcase
		end
		if (sqrt_done) begin
			root_q <= sqrt_root;
		end
		if (cordic_stat.done) begin
			if (state_q == ST_PITCH) begin
				pitch_q <= PITCH_BITS'(cordic_angle);
			end else begin
				roll_q <= cordic_angle;
			end
		end
		if (res_load) begin
			res_missing_q <= missing_q;
			res_dot_x_q   <= missing_q ? '0 : posx_q;
			res_dot_y_q   <= missing_q ? '0 : posy_q;
			res_level_q   <= missing_q ? 1'b0 : level_q;
			res_pitch_q   <= missing_q ? '0 : pitch_q;
			res_roll_q    <= missing_q ? '0 : roll_q;
		end
	end

	`TLP_ASSERT_NEXT(a_loaded_after_sample, clk, arst_n, sample.valid && sample.ready && sample.sensor_present, loaded_q, "smoothing not marked loaded after a present sample")
	`TLP_ASSERT_IMPLY(a_cordic_free, clk, arst_n, cordic_req.start, !cordic_stat.busy && !cordic_stat.done, "CORDIC request while a pass is still running")
	`TLP_ASSERT_IMPLY(a_missing_zero, clk, arst_n, result.valid && result.sensor_missing, result.dot_x == '0 && result.dot_y == '0 && !result.is_level && result.pitch_centideg == '0 && result.roll_centideg == '0, "missing-sensor result carries nonzero fields")
	`TLP_ASSERT_IMPLY(a_angle_range, clk, arst_n, result.valid, result.roll_centideg >= -ROLL_LIMIT && result.roll_centideg <= ROLL_LIMIT && result.pitch_centideg >= -PITCH_LIMIT && result.pitch_centideg <= PITCH_LIMIT, "angle outside its range")

endmodule

@@ sv/tlp_isqrt.sv @@
// Bit-pair restoring integer square root, one result bit per cycle.
// Depends on tlp_pkg for operand widths.
module tlp_isqrt import tlp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            take;
	logic            busy_q;
	logic            fin_q;

	assign trial = r_q + bit_q;
	assign take  = (v_q >= trial);
	assign done  = fin_q;
	assign root  = r_q[ROOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= value;
			r_q   <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (take) begin
				v_q <= v_q - trial;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

@@ sv/tlp_cordic.sv @@
// Vectoring CORDIC: angle of (x, y) in centidegrees, one rotation per cycle.
// Depends on tlp_pkg for widths, limits and the arctangent table.
module tlp_cordic import tlp_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cordic_req_t                 req,
	output cordic_stat_t                stat,
	output logic signed [ROLL_BITS-1:0] angle
);

	localparam int NSTEP  = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int STEP_W = $clog2(NSTEP);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEP - 1);

	logic signed [CORD_W-1:0] x_q, y_q, x_in, y_in, x_sh, y_sh;
	logic signed [ANG_W-1:0]  ang_q, ang_in, atan_s, rnd, lim, clamped;
	logic [STEP_W-1:0]        step_q;
	logic                     busy_q, fin_q, zero_q, sel_pitch_q;

	always_comb begin
		x_in   = CORD_W'(req.x);
		y_in   = CORD_W'(req.y);
		ang_in = '0;
		if (x_in < 0) begin
			ang_in = (y_in >= 0) ? HALF_TURN : -HALF_TURN;
			x_in   = -x_in;
			y_in   = -y_in;
		end
	end

	assign x_sh   = x_q >>> step_q;
	assign y_sh   = y_q >>> step_q;
	assign atan_s = ANG_W'(atan_entry(ATAN_IDX_W'(step_q)));

	always_comb begin
		rnd     = (ang_q + ROUND_HALF) >>> ANG_FRAC;
		lim     = sel_pitch_q ? ANG_W'(PITCH_LIMIT) : ANG_W'(ROLL_LIMIT);
		clamped = rnd;
		if (rnd > lim) begin
			clamped = lim;
		end else if (rnd < -lim) begin
			clamped = -lim;
		end
		angle = zero_q ? '0 : ROLL_BITS'(clamped);
	end

	assign stat.busy = busy_q;
	assign stat.done = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q         <= x_in;
			y_q         <= y_in;
			ang_q       <= ang_in;
			zero_q      <= (req.x == '0) && (req.y == '0);
			sel_pitch_q <= req.sel_pitch;
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q   <= x_q + y_sh;
				y_q   <= y_q - x_sh;
				ang_q <= ang_q + atan_s;
			end else begin
				x_q   <= x_q - y_sh;
				y_q   <= y_q + x_sh;
				ang_q <= ang_q - atan_s;
			end
		end
	end

endmodule

@@ tb/tilt_level_pitch_roll_tb.sv @@
// Testbench for tilt_level_pitch_roll: drives samples and register writes, and
// predicts dot position, level flag, pitch and roll for each accepted request.
// Depends on tlp_pkg, tlp_if and the tilt_level_pitch_roll RTL.
module tilt_level_pitch_roll_tb;
	import tlp_pkg::*;

	typedef struct {
		logic signed [ACCEL_BITS_DEF-1:0] x;
		logic signed [ACCEL_BITS_DEF-1:0] y;
		logic signed [ACCEL_BITS_DEF-1:0] z;
		logic                             restart;
		logic                             present;
	} sample_t;

	typedef struct {
		logic        [DOT_BITS-1:0]   dot_x;
		logic        [DOT_BITS-1:0]   dot_y;
		logic                         is_level;
		logic signed [PITCH_BITS-1:0] pitch;
		logic signed [ROLL_BITS-1:0]  roll;
		logic                         missing;
	} tilt_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tlp_sample_if sample_ch();
	tlp_result_if result_ch();

	tilt_level_pitch_roll u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	longint gain_reg, scale_reg, tol_reg, width_reg, height_reg;
	longint smooth_x, smooth_y;
	bit     smooth_loaded;
	longint atan_cdeg256 [16] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
		11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};

	tilt_t expected_q[$];
	int    mismatches;
	int    send_idle_pct;
	int    recv_idle_pct;
	int    hold_req;
	int    hold_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint px, longint py, longint limit);
		longint ang, sx, sy, r;
		int     i;
		ang = 0;
		if (px == 0 && py == 0)
			return 0;
		if (px < 0) begin
			ang = (py >= 0) ? 18000 * 256 : -18000 * 256;
			px = -px;
			py = -py;
		end
		for (i = 0; i < CORDIC_STEPS_DEF; i++) begin
			sx = px >>> i;
			sy = py >>> i;
			if (py >= 0) begin
				px += sy;
				py -= sx;
				ang += atan_cdeg256[i];
			end else begin
				px -= sy;
				py += sx;
				ang -= atan_cdeg256[i];
			end
		end
		r = (ang + 128) >>> 8;
		if (r > limit)
			r = limit;
		if (r < -limit)
			r = -limit;
		return r;
	endfunction

	function automatic longint place_dot(longint smooth, longint size, output longint off);
		longint center, hi, d, p;
		center = size >> 1;
		hi = size - EDGE_MARGIN;
		d = (smooth * scale_reg) / 1048576;
		p = center + d;
		if (hi < EDGE_MARGIN)
			hi = EDGE_MARGIN;
		if (p < EDGE_MARGIN)
			p = EDGE_MARGIN;
		else if (p > hi)
			p = hi;
		off = p - center;
		return p;
	endfunction

	function automatic tilt_t predict_level(sample_t s);
		tilt_t  r;
		longint ax, ay, az, sx, sy, sz, dx, dy, px, py, pitch, roll;
		longint unsigned mag;
		r.dot_x = '0;
		r.dot_y = '0;
		r.is_level = 1'b0;
		r.pitch = '0;
		r.roll = '0;
		r.missing = 1'b1;
		if (!s.present)
			return r;
		ax = longint'(s.x);
		ay = longint'(s.y);
		az = longint'(s.z);
		if (s.restart)
			smooth_loaded = 1'b0;
		if (!smooth_loaded) begin
			smooth_x = ax * 256;
			smooth_y = ay * 256;
			smooth_loaded = 1'b1;
		end else begin
			smooth_x += ((ax * 256 - smooth_x) * gain_reg) >>> 16;
			smooth_y += ((ay * 256 - smooth_y) * gain_reg) >>> 16;
		end
		px = place_dot(smooth_x, width_reg, dx);
		py = place_dot(smooth_y, height_reg, dy);
		sx = ax * 32768;
		sy = ay * 32768;
		sz = az * 32768;
		mag = floor_sqrt(longint'(unsigned'(sy * sy)) + longint'(unsigned'(sz * sz)));
		roll = vector_angle(sz, sy, ROLL_LIMIT);
		pitch = vector_angle(longint'(mag), -sx, PITCH_LIMIT);
		r.dot_x = DOT_BITS'(px);
		r.dot_y = DOT_BITS'(py);
		r.is_level = (dx * dx + dy * dy) <= tol_reg * tol_reg;
		r.pitch = PITCH_BITS'(pitch);
		r.roll = ROLL_BITS'(roll);
		r.missing = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint want, longint got);
		if (mismatches < 50)
			$display("MISMATCH %s: expected %0d, got %0d at %0t", field, want, got, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin : result_check
		tilt_t got, want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.dot_x = result_ch.dot_x;
			got.dot_y = result_ch.dot_y;
			got.is_level = result_ch.is_level;
			got.pitch = result_ch.pitch_centideg;
			got.roll = result_ch.roll_centideg;
			got.missing = result_ch.sensor_missing;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result, dot_x", 0, got.dot_x);
			end else begin
				want = expected_q.pop_front();
				if (got.dot_x !== want.dot_x)
					report_mismatch("dot_x", want.dot_x, got.dot_x);
				if (got.dot_y !== want.dot_y)
					report_mismatch("dot_y", want.dot_y, got.dot_y);
				if (got.is_level !== want.is_level)
					report_mismatch("is_level", want.is_level, got.is_level);
				if (got.pitch !== want.pitch)
					report_mismatch("pitch_centideg", want.pitch, got.pitch);
				if (got.roll !== want.roll)
					report_mismatch("roll_centideg", want.roll, got.roll);
				if (got.missing !== want.missing)
					report_mismatch("sensor_missing", want.missing, got.missing);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_sample(sample_t s);
		int gap;
		sample_ch.valid <= 1'b1;
		sample_ch.accel_x <= s.x;
		sample_ch.accel_y <= s.y;
		sample_ch.accel_z <= s.z;
		sample_ch.restart <= s.restart;
		sample_ch.sensor_present <= s.present;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		expected_q.push_back(predict_level(s));
		gap = 0;
		while (gap < 400 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, int unsigned value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		case (idx)
			REG_GAIN:   gain_reg = value & 16'hFFFF;
			REG_SCALE:  scale_reg = value & 8'hFF;
			REG_TOL:    tol_reg = value & 8'hFF;
			REG_WIDTH:  width_reg = value & 10'h3FF;
			REG_HEIGHT: height_reg = value & 10'h3FF;
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned gain, int unsigned scale, int unsigned tol,
		int unsigned w, int unsigned h);
		drain_results();
		put_reg(REG_GAIN, gain);
		put_reg(REG_SCALE, scale);
		put_reg(REG_TOL, tol);
		put_reg(REG_WIDTH, w);
		put_reg(REG_HEIGHT, h);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic sample_t make_sample(int x, int y, int z, bit restart = 1'b0,
		bit present = 1'b1);
		sample_t s;
		s.x = ACCEL_BITS_DEF'(x);
		s.y = ACCEL_BITS_DEF'(y);
		s.z = ACCEL_BITS_DEF'(z);
		s.restart = restart;
		s.present = present;
		return s;
	endfunction

	function automatic sample_t random_sample();
		sample_t s;
		int      pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			s = make_sample(int'($urandom_range(12000)) - 6000,
				int'($urandom_range(12000)) - 6000, int'($urandom_range(12000)) - 6000);
		end else if (pick < 70) begin
			s = make_sample(int'($urandom_range(800)) - 400, int'($urandom_range(800)) - 400,
				4096 + int'($urandom_range(800)) - 400);
		end else if (pick < 90) begin
			s = make_sample($urandom, $urandom, $urandom);
		end else begin
			s = make_sample($urandom, $urandom, $urandom);
			if ($urandom_range(1)) s.x = '0;
			if ($urandom_range(1)) s.y = '0;
			if ($urandom_range(1)) s.z = '0;
		end
		s.restart = ($urandom_range(99) < 4);
		s.present = ($urandom_range(99) >= 6);
		return s;
	endfunction

	task automatic test_directed_extremes();
		send_sample(make_sample(0, 0, 4096));
		send_sample(make_sample(0, 0, 0));
		send_sample(make_sample(0, 0, -4096));
		send_sample(make_sample(-32768, -32768, -32768));
		send_sample(make_sample(32767, 32767, 32767));
		send_sample(make_sample(-32768, 32767, 0));
		send_sample(make_sample(32767, -32768, 0));
		send_sample(make_sample(4096, 0, 0));
		send_sample(make_sample(-4096, 0, 0));
		send_sample(make_sample(12345, -23456, 777, 1'b1, 1'b0));
		send_sample(make_sample(0, 4096, 0));
		send_sample(make_sample(2048, -2048, 4096, 1'b1));
		send_sample(make_sample(0, -4096, 0));
		send_sample(make_sample(0, 0, 32767));
		send_sample(make_sample(1, -1, 1));
		send_sample(make_sample(-1, 1, -1));
	endtask

	task automatic test_narrow_area();
		configure(GAIN_RESET, 255, 255, 10, 15);
		send_sample(make_sample(32767, -32768, 4096, 1'b1));
		send_sample(make_sample(0, 0, 4096));
		configure(GAIN_RESET, 200, 3, 0, 16);
		send_sample(make_sample(-20000, 20000, -4096, 1'b1));
		send_sample(make_sample(300, -300, 4096));
	endtask

	task automatic test_register_extremes();
		configure(0, 0, 0, 1023, 1023);
		send_sample(make_sample(4096, -4096, 0, 1'b1));
		send_sample(make_sample(-32768, 32767, 100));
		configure(65535, 255, 255, 16, 1023);
		send_sample(make_sample(-8000, 8000, 4096, 1'b1));
		send_sample(make_sample(8000, -8000, 4096));
		send_sample(make_sample(0, 0, 4096));
		configure(65535, 255, 0, 1023, 16);
		send_sample(make_sample(0, 0, 4096));
		send_sample(make_sample(32767, 32767, -1));
	endtask

	task automatic test_random_traffic();
		int send_pct [4] = '{0, 78, 0, 13};
		int recv_pct [4] = '{0, 0, 78, 13};
		int unsigned gain;
		int phase, n;
		for (phase = 0; phase < 4; phase++) begin
			case ($urandom_range(3))
				0:       gain = 0;
				1:       gain = 65535;
				default: gain = $urandom_range(65535);
			endcase
			configure(gain, $urandom_range(255) | ($urandom << 8),
				$urandom_range(255) | ($urandom << 8),
				($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(1023, 16))
					| ($urandom << 10),
				($urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(1023, 16))
					| ($urandom << 10));
			send_idle_pct = send_pct[phase];
			recv_idle_pct = recv_pct[phase];
			for (n = 0; n < 240; n++)
				send_sample(random_sample());
		end
		drain_results();
		send_idle_pct = 0;
		recv_idle_pct = 0;
	endtask

	task automatic test_input_backpressure();
		int n;
		configure(GAIN_RESET, SCALE_RESET, TOL_RESET, WIDTH_RESET, HEIGHT_RESET);
		hold_req = 800;
		for (n = 0; n < 24; n++)
			send_sample(random_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_GAIN;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.accel_x = '0;
		sample_ch.accel_y = '0;
		sample_ch.accel_z = '0;
		sample_ch.restart = 1'b0;
		sample_ch.sensor_present = 1'b0;
		result_ch.ready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 0;
		hold_left = 0;
		gain_reg = GAIN_RESET;
		scale_reg = SCALE_RESET;
		tol_reg = TOL_RESET;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		smooth_x = 0;
		smooth_y = 0;
		smooth_loaded = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_narrow_area();
		test_register_extremes();
		test_random_traffic();
		test_input_backpressure();

		drain_results();
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

@@ tilt_level_pitch_roll.f @@
+incdir+sv
sv/tlp_pkg.sv
sv/tlp_if.sv
sv/tlp_isqrt.sv
sv/tlp_cordic.sv
sv/tilt_level_pitch_roll.sv
tb/tilt_level_pitch_roll_tb.sv
